// ----- hdl/nru_set_assoc_cache_sim_defines.svh -----
// Assertion macros for the NRU set-associative cache lookup block.
// Included by the top level; simulation gets real checks, synthesis gets nothing.
`ifndef NRU_SET_ASSOC_CACHE_SIM_DEFINES_SVH
`define NRU_SET_ASSOC_CACHE_SIM_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define NRUSC_ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("nrusc: assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define NRUSC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("nrusc: assertion failed");
`else
`define NRUSC_ASSERT_IMPLY(label, clk, rst_n, pre, post)
`define NRUSC_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// ----- hdl/nrusc_pkg.sv -----
// Shared types and constants of the NRU set-associative cache lookup block.
// No dependencies; imported by every module of the block except nrusc_queue.
`timescale 1ns / 1ps

package nrusc_pkg;

    localparam int ADDR_W     = 32;
    localparam int TAG_W      = 32;
    localparam int POS_W      = 5;
    localparam int MASK_W     = 32;
    localparam int WAYS_CFG_W = 4;
    localparam int OUT_WAY_W  = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_INDEX_MASK  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE = 1'b1;

    localparam logic [MASK_W-1:0]     MASK_RESET = 32'h0000_00FF;
    localparam logic [WAYS_CFG_W-1:0] WAYS_RESET = 4'd4;
    localparam logic [31:0]           MISS_MAX   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [MASK_W-1:0]     index_mask;
        logic [WAYS_CFG_W-1:0] ways_in_use;
    } cfg_t;

    typedef struct packed {
        logic                 done;
        logic                 hit;
        logic [OUT_WAY_W-1:0] way;
        logic [31:0]          miss_count;
    } result_t;

endpackage

// ----- hdl/nrusc_front.sv -----
// Front end: index/tag bit map built from the index mask, address split and intake.
// Depends on nrusc_pkg; feeds nrusc_queue.
`timescale 1ns / 1ps

module nrusc_front
    import nrusc_pkg::*;
#(
    parameter int SET_BITS  = 8,
    parameter int ADDR_BITS = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [ADDR_W-1:0]         block_address,
    input  cfg_t                      cfg,
    input  logic                      map_restart,
    input  logic                      q_full,
    input  logic                      back_clearing,
    output logic                      busy,
    output logic                      q_push,
    output logic [SET_BITS+TAG_W-1:0] q_push_data
);

    localparam int MAP_BITS = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam int BIT_W    = (MAP_BITS > 1) ? $clog2(MAP_BITS) : 1;
    localparam int NSET_W   = $clog2(SET_BITS + 1);

    // Per address bit: whether it goes to the set index, and its position there or in the tag.
    logic [POS_W-1:0] dest_reg [MAP_BITS];
    logic             is_set_reg [MAP_BITS];

    logic              map_busy_reg, map_busy_next;
    logic [BIT_W-1:0]  map_bit_reg, map_bit_next;
    logic [NSET_W-1:0] nset_reg, nset_next;
    logic [POS_W-1:0]  ntag_reg, ntag_next;
    logic              to_set;

    logic [SET_BITS-1:0] set_idx;
    logic [TAG_W-1:0]    tag_val;

    assign to_set = cfg.index_mask[map_bit_reg] && (nset_reg < NSET_W'(SET_BITS));

    always_comb
    begin
        map_busy_next = map_busy_reg;
        map_bit_next  = map_bit_reg;
        nset_next     = nset_reg;
        ntag_next     = ntag_reg;
        if (map_restart)
        begin
            map_busy_next = 1'b1;
            map_bit_next  = '0;
            nset_next     = '0;
            ntag_next     = '0;
        end
        else if (map_busy_reg)
        begin
            if (map_bit_reg == BIT_W'(MAP_BITS - 1))
            begin
                map_busy_next = 1'b0;
            end
            map_bit_next = map_bit_reg + 1'b1;
            if (to_set)
            begin
                nset_next = nset_reg + 1'b1;
            end
            else
            begin
                ntag_next = ntag_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_busy_reg <= 1'b1;
            map_bit_reg  <= '0;
            nset_reg     <= '0;
            ntag_reg     <= '0;
        end
        else
        begin
            map_busy_reg <= map_busy_next;
            map_bit_reg  <= map_bit_next;
            nset_reg     <= nset_next;
            ntag_reg     <= ntag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (map_busy_reg && !map_restart)
        begin
            is_set_reg[map_bit_reg] <= to_set;
            dest_reg[map_bit_reg]   <= to_set ? POS_W'(nset_reg) : ntag_reg;
        end
    end

    // Gather the address bits through the map; each output bit is an OR over the address.
    always_comb
    begin
        set_idx = '0;
        tag_val = '0;
        for (int i = 0; i < MAP_BITS; i++)
        begin
            for (int k = 0; k < SET_BITS; k++)
            begin
                if (is_set_reg[i] && (dest_reg[i] == POS_W'(k)))
                begin
                    set_idx[k] = set_idx[k] | block_address[i];
                end
            end
            for (int k = 0; k < TAG_W; k++)
            begin
                if (!is_set_reg[i] && (dest_reg[i] == POS_W'(k)))
                begin
                    tag_val[k] = tag_val[k] | block_address[i];
                end
            end
        end
    end

    assign busy        = map_busy_reg | q_full | back_clearing;
    assign q_push      = start & ~busy;
    assign q_push_data = {set_idx, tag_val};

endmodule

// ----- hdl/nrusc_queue.sv -----
// Two-entry queue carrying split lookups from the front end to the back end.
// Depends on nothing but its width parameter.
`timescale 1ns / 1ps

module nrusc_queue #(
    parameter int DATA_W = 40
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              full,
    output logic              empty
);

    logic [DATA_W-1:0] entry_reg [2];
    logic [1:0]        count_reg, count_next;
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic              do_push, do_pop;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign do_push  = push & ~full;
    assign do_pop   = pop & ~empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next  = count_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (do_pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- hdl/nrusc_back.sv -----
// Back end: tag and status memories, clearing pass, NRU lookup and update, miss counter.
// Depends on nrusc_pkg; drains nrusc_queue.
`timescale 1ns / 1ps

module nrusc_back
    import nrusc_pkg::*;
#(
    parameter int WAYS     = 8,
    parameter int SET_BITS = 8
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cfg_t                      cfg,
    input  logic                      q_empty,
    input  logic [SET_BITS+TAG_W-1:0] q_data,
    output logic                      q_pop,
    output logic                      clearing,
    output result_t                   res
);

    localparam int NUM_SETS = 1 << SET_BITS;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int N_W      = $clog2(WAYS + 1);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_LOOK  = 2'd2;

    // Tags per set and way; status row per set is {nru bits, valid bits}.
    logic [TAG_W-1:0]  tag_mem [NUM_SETS][WAYS];
    logic [2*WAYS-1:0] stat_mem [NUM_SETS];

    logic [1:0]          state_reg, state_next;
    logic [SET_BITS-1:0] clr_cnt_reg, clr_cnt_next;
    logic [31:0]         miss_cnt_reg, miss_cnt_next;
    logic                done_reg, done_next;
    logic                hit_reg;
    logic [OUT_WAY_W-1:0] way_reg;

    logic [SET_BITS-1:0] set_reg;
    logic [TAG_W-1:0]    tag_reg;
    logic [TAG_W-1:0]    tag_row_reg [WAYS];
    logic [2*WAYS-1:0]   stat_row_reg;

    logic [SET_BITS-1:0] q_set;
    logic [TAG_W-1:0]    q_tag;

    logic [N_W-1:0]      n_act;
    logic [WAYS-1:0]     inuse, match, cand;
    logic [WAYS-1:0]     valid_row, nru_row, valid_new, nru_new;
    logic                any_hit;
    logic [WAY_W-1:0]    hit_way, victim, use_way;

    logic                tag_we, stat_we;
    logic [SET_BITS-1:0] stat_waddr;
    logic [2*WAYS-1:0]   stat_wdata;

    assign q_set = q_data[SET_BITS+TAG_W-1:TAG_W];
    assign q_tag = q_data[TAG_W-1:0];

    always_comb
    begin
        if (cfg.ways_in_use == '0)
        begin
            n_act = N_W'(1);
        end
        else if (int'(cfg.ways_in_use) > WAYS)
        begin
            n_act = N_W'(WAYS);
        end
        else
        begin
            n_act = N_W'(cfg.ways_in_use);
        end
    end

    assign valid_row = stat_row_reg[WAYS-1:0];
    assign nru_row   = stat_row_reg[2*WAYS-1:WAYS];

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            inuse[w] = (w < int'(n_act));
            match[w] = inuse[w] && valid_row[w] && (tag_row_reg[w] == tag_reg);
        end
        any_hit = |match;
        cand    = nru_row & inuse;

        hit_way = '0;
        victim  = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (match[w])
            begin
                hit_way = WAY_W'(w);
            end
            if (cand[w])
            begin
                victim = WAY_W'(w);
            end
        end

        valid_new = valid_row;
        if (any_hit)
        begin
            // Every matching way is marked recently used; the lowest is reported.
            use_way = hit_way;
            nru_new = nru_row & ~match;
        end
        else
        begin
            // With no candidate left, all ways in use are marked and way 0 is refilled.
            use_way = (|cand) ? victim : '0;
            nru_new = (|cand) ? nru_row : (nru_row | inuse);
            nru_new[use_way]   = 1'b0;
            valid_new[use_way] = 1'b1;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        done_next     = 1'b0;
        q_pop         = 1'b0;
        tag_we        = 1'b0;
        stat_we       = 1'b0;
        stat_waddr    = set_reg;
        stat_wdata    = {nru_new, valid_new};
        case (state_reg)
            S_CLEAR:
            begin
                stat_we      = 1'b1;
                stat_waddr   = clr_cnt_reg;
                stat_wdata   = {{WAYS{1'b1}}, {WAYS{1'b0}}};
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == SET_BITS'(NUM_SETS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                stat_we    = 1'b1;
                tag_we     = ~any_hit;
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (!any_hit && (miss_cnt_reg != MISS_MAX))
                begin
                    miss_cnt_next = miss_cnt_reg + 32'd1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            miss_cnt_reg <= miss_cnt_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            set_reg      <= q_set;
            tag_reg      <= q_tag;
            tag_row_reg  <= tag_mem[q_set];
            stat_row_reg <= stat_mem[q_set];
        end
        if (state_reg == S_LOOK)
        begin
            hit_reg <= any_hit;
            way_reg <= OUT_WAY_W'(use_way);
        end
    end

    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[set_reg][use_way] <= tag_reg;
        end
        if (stat_we)
        begin
            stat_mem[stat_waddr] <= stat_wdata;
        end
    end

    assign clearing       = (state_reg == S_CLEAR);
    assign res.done       = done_reg;
    assign res.hit        = hit_reg;
    assign res.way        = way_reg;
    assign res.miss_count = miss_cnt_reg;

endmodule

// ----- hdl/nru_set_assoc_cache_sim.sv -----
// Top level of the NRU set-associative cache lookup block: configuration registers and wiring.
// Depends on nrusc_pkg, nrusc_front, nrusc_queue, nrusc_back and the defines header.
`timescale 1ns / 1ps
`include "nru_set_assoc_cache_sim_defines.svh"

// An address is accepted when start is high and busy is low. Its result appears on hit, way
// and miss_count with done high for one cycle. On its way the address passes through the queue,
// the row read and the lookup state of the back end. The receiver cannot stall the result.
// For each lookup the back end first reads the set's tag and status row, then updates that row
// through the single write port. It pops the next item only after that update, and a two-entry
// queue lets the front keep accepting meanwhile.
// After reset, busy stays high until two things are done: the clearing pass over all 2**SET_BITS
// sets of the status memory, and the build of the index bit map over min(ADDR_BITS, 32) address
// bits. Each write of index_mask rebuilds that map and holds busy until the rebuild is done.
module nru_set_assoc_cache_sim
    import nrusc_pkg::*;
#(
    parameter int WAYS      = 8,
    parameter int SET_BITS  = 8,
    parameter int ADDR_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [ADDR_W-1:0]     block_address,
    output logic                  done,
    output logic                  hit,
    output logic [OUT_WAY_W-1:0]  way,
    output logic [31:0]           miss_count,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int Q_W = SET_BITS + TAG_W;

    logic [MASK_W-1:0]     index_mask_reg, index_mask_next;
    logic [WAYS_CFG_W-1:0] ways_reg, ways_next;
    cfg_t                  cfg;
    logic                  map_restart;

    logic           q_push, q_pop, q_full, q_empty;
    logic [Q_W-1:0] q_push_data, q_pop_data;
    logic           back_clearing;
    result_t        res;

    always_comb
    begin
        index_mask_next = index_mask_reg;
        ways_next       = ways_reg;
        map_restart     = 1'b0;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_INDEX_MASK:
                begin
                    index_mask_next = cfg_data[MASK_W-1:0];
                    map_restart     = 1'b1;
                end
                REG_WAYS_IN_USE:
                begin
                    ways_next = cfg_data[WAYS_CFG_W-1:0];
                end
                default:
                begin
                    ways_next = ways_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_mask_reg <= MASK_RESET;
            ways_reg       <= WAYS_RESET;
        end
        else
        begin
            index_mask_reg <= index_mask_next;
            ways_reg       <= ways_next;
        end
    end

    assign cfg.index_mask  = index_mask_reg;
    assign cfg.ways_in_use = ways_reg;

    nrusc_front #(
        .SET_BITS  (SET_BITS),
        .ADDR_BITS (ADDR_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .block_address (block_address),
        .cfg           (cfg),
        .map_restart   (map_restart),
        .q_full        (q_full),
        .back_clearing (back_clearing),
        .busy          (busy),
        .q_push        (q_push),
        .q_push_data   (q_push_data)
    );

    nrusc_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    nrusc_back #(
        .WAYS     (WAYS),
        .SET_BITS (SET_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_empty  (q_empty),
        .q_data   (q_pop_data),
        .q_pop    (q_pop),
        .clearing (back_clearing),
        .res      (res)
    );

    assign done       = res.done;
    assign hit        = res.hit;
    assign way        = res.way;
    assign miss_count = res.miss_count;

    // An accepted transfer is in the queue at the next edge, even if the back end pops then.
    `NRUSC_ASSERT_NEXT(a_push_lands, clk, rst_n, q_push, !q_empty)
    // No result can come out while the status memory is still being cleared.
    `NRUSC_ASSERT_IMPLY(a_quiet_in_clear, clk, rst_n, back_clearing, !res.done)
    // The back end returns to its idle state after each lookup, so results never come back to back.
    `NRUSC_ASSERT_NEXT(a_result_spacing, clk, rst_n, res.done, !res.done)
    // A reported miss has always been counted.
    `NRUSC_ASSERT_IMPLY(a_miss_counted, clk, rst_n, res.done && !res.hit, res.miss_count != '0)

endmodule
